// ===== hdl/cclc_pkg.sv =====
package cclc_pkg;

   localparam int ROW_WIDTH_DEFAULT = 20;
   localparam int COL_WIDTH_DEFAULT = 16;

   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_NL     = 8'h0A;

   localparam logic [3:0] CHAR_LIMIT_RESET = 4'd4;

   localparam int QCOUNT_WIDTH = 5;
   localparam logic [QCOUNT_WIDTH-1:0] QCOUNT_MAX = '1;

   // lexer context carried from byte to byte
   typedef struct packed {
      logic [31:0]             history;
      logic                    seen_byte;
      logic                    in_str;
      logic                    in_sq;
      logic                    skip_line;
      logic                    skip_block;
      logic [QCOUNT_WIDTH-1:0] qcount;
   } cclc_lex_type;

   localparam cclc_lex_type LEX_RESET = '0;

endpackage

// ===== hdl/c_char_literal_length_checker_core.sv =====
// channel | ports                                              | direction
// --------+----------------------------------------------------+----------
// req     | req_valid, req_stall, req_source_byte, req_end_of_file | in
// rsp     | rsp_valid, rsp_stall, rsp_found, rsp_row_number,   | out
//         | rsp_column_number                                  |
// csr     | csr_valid, csr_ready, csr_char_limit               | in
//
// One byte per cycle sustained while the result is not stalled; a beat passes an
// input register and reaches the result register when that stage advances.
// A byte is held one beat for lookahead, so the final byte runs two scan units
// in series in the same cycle.
// Synchronous active-high reset; char_limit resets to 4.
// The input stage holds while a result sits stalled at the output.
module c_char_literal_length_checker_core
   import cclc_pkg::*;
#(
   parameter int ROW_WIDTH = ROW_WIDTH_DEFAULT,
   parameter int COL_WIDTH = COL_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_source_byte,
   input  logic                 req_end_of_file,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   output logic [ROW_WIDTH-1:0] rsp_row_number,
   output logic [COL_WIDTH-1:0] rsp_column_number,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [3:0]           csr_char_limit
);

   logic                 stg_valid_ff, stg_valid_in;
   logic [7:0]           stg_byte_ff;
   logic                 stg_eof_ff;
   logic                 advance, accept;

   logic [3:0]           limit_ff;
   cclc_lex_type         lex_ff, lex_in;
   logic [ROW_WIDTH-1:0] row_ff, row_in;
   logic [COL_WIDTH-1:0] col_ff, col_in;
   logic                 reported_ff, reported_in;
   logic [7:0]           pend_byte_ff;
   logic                 pend_valid_ff;

   logic                 rsp_valid_ff, rsp_found_ff;
   logic [ROW_WIDTH-1:0] rsp_row_ff;
   logic [COL_WIDTH-1:0] rsp_col_ff;

   cclc_lex_type         lex_a, lex_a_sel, lex_b;
   logic [ROW_WIDTH-1:0] row_a, row_a_sel, row_b;
   logic [COL_WIDTH-1:0] col_a, col_a_sel, col_b;
   logic                 hit_a_raw, hit_a, hit_b, hit, produce;

   assign advance   = stg_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = stg_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign stg_valid_in = accept || (stg_valid_ff && !advance);
   assign csr_ready = 1'b1;

   // held byte, looking ahead at the incoming one
   cclc_scan #(.ROW_WIDTH(ROW_WIDTH), .COL_WIDTH(COL_WIDTH)) u_scan_held (
      .lex_cur    (lex_ff),
      .row_cur    (row_ff),
      .col_cur    (col_ff),
      .cur_byte   (pend_byte_ff),
      .next_byte  (stg_byte_ff),
      .pair_ok    (!stg_eof_ff),
      .char_limit (limit_ff),
      .lex_nxt    (lex_a),
      .row_nxt    (row_a),
      .col_nxt    (col_a),
      .hit        (hit_a_raw)
   );

   assign hit_a     = pend_valid_ff && hit_a_raw;
   assign lex_a_sel = pend_valid_ff ? lex_a : lex_ff;
   assign row_a_sel = pend_valid_ff ? row_a : row_ff;
   assign col_a_sel = pend_valid_ff ? col_a : col_ff;

   // final byte of a file, no lookahead
   cclc_scan #(.ROW_WIDTH(ROW_WIDTH), .COL_WIDTH(COL_WIDTH)) u_scan_last (
      .lex_cur    (lex_a_sel),
      .row_cur    (row_a_sel),
      .col_cur    (col_a_sel),
      .cur_byte   (stg_byte_ff),
      .next_byte  (8'd0),
      .pair_ok    (1'b0),
      .char_limit (limit_ff),
      .lex_nxt    (lex_b),
      .row_nxt    (row_b),
      .col_nxt    (col_b),
      .hit        (hit_b)
   );

   assign hit     = !reported_ff && (hit_a || (stg_eof_ff && hit_b));
   assign produce = !reported_ff && (hit || stg_eof_ff);

   always_comb begin
      lex_in      = lex_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      reported_in = reported_ff;
      if (stg_eof_ff) begin
         lex_in      = LEX_RESET;
         row_in      = {{(ROW_WIDTH-1){1'b0}}, 1'b1};
         col_in      = '0;
         reported_in = 1'b0;
      end else if (!reported_ff) begin
         lex_in      = lex_a_sel;
         row_in      = row_a_sel;
         col_in      = col_a_sel;
         reported_in = hit_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff  <= 1'b0;
         limit_ff      <= CHAR_LIMIT_RESET;
         lex_ff        <= LEX_RESET;
         row_ff        <= {{(ROW_WIDTH-1){1'b0}}, 1'b1};
         col_ff        <= '0;
         reported_ff   <= 1'b0;
         pend_byte_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_char_limit;
         end
         if (advance) begin
            lex_ff        <= lex_in;
            row_ff        <= row_in;
            col_ff        <= col_in;
            reported_ff   <= reported_in;
            pend_byte_ff  <= stg_eof_ff ? 8'd0 : stg_byte_ff;
            pend_valid_ff <= !stg_eof_ff;
            rsp_valid_ff  <= produce;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_byte_ff <= req_source_byte;
         stg_eof_ff  <= req_end_of_file;
      end
      if (advance && produce) begin
         rsp_found_ff <= hit;
         rsp_row_ff   <= !hit ? '0 : (hit_a ? row_a : row_b);
         rsp_col_ff   <= !hit ? '0 : (hit_a ? col_a : col_b);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_row_number    = rsp_row_ff;
   assign rsp_column_number = rsp_col_ff;

   a_clean_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_row_number == '0 && rsp_column_number == '0)
      else $error("clean result with nonzero position");

   a_found_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_row_number != '0)
      else $error("detection reported on row zero");

   a_eof_clears: assert property (@(posedge clock) disable iff (reset)
      advance && stg_eof_ff |=> !pend_valid_ff && !reported_ff)
      else $error("file state not cleared after final byte");

   a_report_sticky: assert property (@(posedge clock) disable iff (reset)
      reported_ff && !(advance && stg_eof_ff) |=> reported_ff)
      else $error("reported flag dropped inside a file");

   a_one_report: assert property (@(posedge clock) disable iff (reset)
      advance && reported_ff |-> !produce)
      else $error("second result within one file");

endmodule

// ===== hdl/cclc_scan.sv =====
module cclc_scan
   import cclc_pkg::*;
#(
   parameter int ROW_WIDTH = ROW_WIDTH_DEFAULT,
   parameter int COL_WIDTH = COL_WIDTH_DEFAULT
) (
   input  cclc_lex_type         lex_cur,
   input  logic [ROW_WIDTH-1:0] row_cur,
   input  logic [COL_WIDTH-1:0] col_cur,
   input  logic [7:0]           cur_byte,
   input  logic [7:0]           next_byte,
   input  logic                 pair_ok,
   input  logic [3:0]           char_limit,
   output cclc_lex_type         lex_nxt,
   output logic [ROW_WIDTH-1:0] row_nxt,
   output logic [COL_WIDTH-1:0] col_nxt,
   output logic                 hit
);

   logic is_nl, is_dq, is_sq, closable, b1, b2, b3, b4;
   logic opened, opened_sq, close_sq;

   assign is_nl = (cur_byte == CH_NL);
   assign is_dq = (cur_byte == CH_DQUOTE);
   assign is_sq = (cur_byte == CH_SQUOTE);

   // escape rule on the last four bytes; unseen bytes read as zero
   assign b1 = (lex_cur.history[7:0]   == CH_BSLASH);
   assign b2 = (lex_cur.history[15:8]  == CH_BSLASH);
   assign b3 = (lex_cur.history[23:16] == CH_BSLASH);
   assign b4 = (lex_cur.history[31:24] == CH_BSLASH);
   assign closable = lex_cur.seen_byte && (!b1 || b2) && (!(b1 && b2 && b3) || b4);

   assign opened    = is_dq && !lex_cur.in_str && !lex_cur.in_sq;
   assign opened_sq = is_sq && !lex_cur.in_sq;
   assign close_sq  = closable && is_sq && lex_cur.in_sq;

   always_comb begin
      lex_nxt = lex_cur;
      row_nxt = row_cur;
      col_nxt = col_cur;
      hit     = 1'b0;

      if (pair_ok && cur_byte == CH_SLASH && next_byte == CH_SLASH &&
          !lex_cur.in_str && !lex_cur.in_sq) begin
         lex_nxt.skip_line = 1'b1;
      end
      if (pair_ok && cur_byte == CH_SLASH && next_byte == CH_STAR &&
          !lex_cur.in_str && !lex_cur.in_sq) begin
         lex_nxt.skip_block = 1'b1;
      end
      if (is_nl) begin
         if (!(&row_cur)) begin
            row_nxt = row_cur + 1'b1;
         end
         col_nxt = '0;
         lex_nxt.skip_line = 1'b0;
      end
      // star-slash closes a block comment unless a line comment is open
      if (!lex_nxt.skip_line && pair_ok && cur_byte == CH_STAR && next_byte == CH_SLASH) begin
         lex_nxt.skip_block = 1'b0;
      end

      if (!lex_nxt.skip_line && !lex_nxt.skip_block) begin
         lex_nxt.in_str = opened || (lex_cur.in_str && !(closable && is_dq));
         if (!(&col_nxt)) begin
            col_nxt = col_nxt + 1'b1;
         end
         if (!lex_nxt.in_str) begin
            lex_nxt.in_sq = (lex_cur.in_sq || opened_sq) && !close_sq;
            if (close_sq) begin
               lex_nxt.qcount = '0;
            end else if (lex_cur.in_sq && lex_cur.qcount != QCOUNT_MAX) begin
               lex_nxt.qcount = lex_cur.qcount + 1'b1;
            end
            hit = (lex_nxt.qcount > {1'b0, char_limit});
         end
      end

      lex_nxt.history   = {lex_cur.history[23:0], cur_byte};
      lex_nxt.seen_byte = 1'b1;
   end

endmodule

// ===== sim/c_char_literal_length_checker_core_tb.sv =====
module c_char_literal_length_checker_core_tb;
   import cclc_pkg::*;

   localparam int RW = ROW_WIDTH_DEFAULT;
   localparam int CW = COL_WIDTH_DEFAULT;

   typedef struct packed {
      logic          found;
      logic [RW-1:0] row;
      logic [CW-1:0] col;
   } verdict_type;

   // one directed beat; typed rows carry their own expected verdict
   typedef struct packed {
      logic [7:0]    data;
      logic          last;
      logic          typed;
      logic          has_res;
      logic          found;
      logic [RW-1:0] row;
      logic [CW-1:0] col;
   } plan_row_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic [7:0]    req_source_byte;
   logic          req_end_of_file;
   logic          rsp_valid;
   logic          rsp_stall;
   logic          rsp_found;
   logic [RW-1:0] rsp_row_number;
   logic [CW-1:0] rsp_column_number;
   logic          csr_valid;
   logic          csr_ready;
   logic [3:0]    csr_char_limit;

   c_char_literal_length_checker_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_source_byte   (req_source_byte),
      .req_end_of_file   (req_end_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_row_number    (rsp_row_number),
      .rsp_column_number (rsp_column_number),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_char_limit    (csr_char_limit)
   );

   // lexer state mirrored on the testbench side
   logic [3:0]    limit_q;
   logic [7:0]    pend_byte;
   bit            pend_ok;
   logic [31:0]   hist;
   bit            seen;
   bit            in_str;
   bit            in_sq;
   bit            skip_line;
   bit            skip_block;
   logic [4:0]    qcnt;
   logic [RW-1:0] row;
   logic [CW-1:0] col;
   bit            reported;

   verdict_type   verdicts[$];
   logic [7:0]    src[$];
   verdict_type   head;
   int            errors = 0;
   int            tx_pct = 0;
   int            rx_pct = 0;
   int            hold_req = 0;

   plan_row_type plan [25] = '{
      '{8'h00,     1'b1, 1'b1, 1'b1, 1'b0, 20'd0, 16'd0},
      '{8'hFF,     1'b1, 1'b1, 1'b1, 1'b0, 20'd0, 16'd0},
      // five chars in quotes against the reset limit of four
      '{CH_SQUOTE, 1'b0, 1'b1, 1'b0, 1'b0, 20'd0, 16'd0},
      '{"a",       1'b0, 1'b1, 1'b0, 1'b0, 20'd0, 16'd0},
      '{"b",       1'b0, 1'b1, 1'b0, 1'b0, 20'd0, 16'd0},
      '{"c",       1'b0, 1'b1, 1'b0, 1'b0, 20'd0, 16'd0},
      '{"d",       1'b0, 1'b1, 1'b0, 1'b0, 20'd0, 16'd0},
      '{"e",       1'b0, 1'b1, 1'b0, 1'b0, 20'd0, 16'd0},
      '{"Z",       1'b0, 1'b1, 1'b1, 1'b1, 20'd1, 16'd6},
      '{"Q",       1'b1, 1'b1, 1'b0, 1'b0, 20'd0, 16'd0},
      // escaped quote keeps the literal open
      '{CH_SQUOTE, 1'b0, 1'b0, 1'b0, 1'b0, 20'd0, 16'd0},
      '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 1'b0, 20'd0, 16'd0},
      '{CH_SQUOTE, 1'b0, 1'b0, 1'b0, 1'b0, 20'd0, 16'd0},
      '{"x",       1'b0, 1'b0, 1'b0, 1'b0, 20'd0, 16'd0},
      '{"y",       1'b0, 1'b0, 1'b0, 1'b0, 20'd0, 16'd0},
      '{"z",       1'b1, 1'b0, 1'b0, 1'b0, 20'd0, 16'd0},
      // block comment hides a quote
      '{CH_SLASH,  1'b0, 1'b0, 1'b0, 1'b0, 20'd0, 16'd0},
      '{CH_STAR,   1'b0, 1'b0, 1'b0, 1'b0, 20'd0, 16'd0},
      '{CH_NL,     1'b0, 1'b0, 1'b0, 1'b0, 20'd0, 16'd0},
      '{CH_SQUOTE, 1'b0, 1'b0, 1'b0, 1'b0, 20'd0, 16'd0},
      '{"x",       1'b1, 1'b0, 1'b0, 1'b0, 20'd0, 16'd0},
      // empty literal at file start
      '{CH_SQUOTE, 1'b0, 1'b0, 1'b0, 1'b0, 20'd0, 16'd0},
      '{CH_SQUOTE, 1'b0, 1'b0, 1'b0, 1'b0, 20'd0, 16'd0},
      '{8'h80,     1'b0, 1'b0, 1'b0, 1'b0, 20'd0, 16'd0},
      '{CH_NL,     1'b1, 1'b0, 1'b0, 1'b0, 20'd0, 16'd0}
   };

   logic [3:0] limit_plan [8] = '{4'd15, 4'd0, 4'd1, 4'd7, 4'd15, 4'd2, 4'd4, 4'd9};

   function automatic void start_file();
      pend_byte  = 8'h00;
      pend_ok    = 1'b0;
      hist       = '0;
      seen       = 1'b0;
      in_str     = 1'b0;
      in_sq      = 1'b0;
      skip_line  = 1'b0;
      skip_block = 1'b0;
      qcnt       = '0;
      row        = {{(RW-1){1'b0}}, 1'b1};
      col        = '0;
      reported   = 1'b0;
   endfunction

   // a quote closes unless an odd run of backslashes (up to four back) precedes it
   function automatic bit close_ok();
      bit b1, b2, b3, b4;
      b1 = hist[7:0] == CH_BSLASH;
      b2 = hist[15:8] == CH_BSLASH;
      b3 = hist[23:16] == CH_BSLASH;
      b4 = hist[31:24] == CH_BSLASH;
      return ((b1 && b2) || !b1) && (!(b1 && b2 && b3) || b4);
   endfunction

   function automatic bit lex_byte(input logic [7:0] c, input logic [7:0] nxt, input bit pair_ok);
      bit hit, opened, opened_sq, closable;
      hit = 1'b0;
      if (pair_ok && c == CH_SLASH && nxt == CH_SLASH && !in_str && !in_sq)
         skip_line = 1'b1;
      if (pair_ok && c == CH_SLASH && nxt == CH_STAR && !in_str && !in_sq)
         skip_block = 1'b1;
      if (c == CH_NL) begin
         if (row != '1)
            row++;
         col = '0;
         skip_line = 1'b0;
      end
      if (!skip_line) begin
         if (pair_ok && c == CH_STAR && nxt == CH_SLASH)
            skip_block = 1'b0;
         if (!skip_block) begin
            closable = seen && close_ok();
            opened = 1'b0;
            if (c == CH_DQUOTE && !in_str && !in_sq) begin
               in_str = 1'b1;
               opened = 1'b1;
            end
            if (closable && c == CH_DQUOTE && in_str && !opened)
               in_str = 1'b0;
            if (col != '1)
               col++;
            if (!in_str) begin
               opened_sq = 1'b0;
               if (c == CH_SQUOTE && !in_sq) begin
                  in_sq = 1'b1;
                  opened_sq = 1'b1;
               end
               if (closable && c == CH_SQUOTE && in_sq && !opened_sq) begin
                  in_sq = 1'b0;
                  qcnt = '0;
               end
               if (in_sq && !opened_sq && qcnt != 5'd31)
                  qcnt++;
               if (qcnt > limit_q)
                  hit = 1'b1;
            end
         end
      end
      hist = {hist[23:0], c};
      seen = 1'b1;
      return hit;
   endfunction

   // one accepted beat; the held byte is scanned with this one as lookahead
   function automatic void take_byte(input logic [7:0] b, input bit e,
                                     output bit got, output verdict_type v);
      bit hit;
      got = 1'b0;
      v = '0;
      if (!reported) begin
         hit = 1'b0;
         if (pend_ok)
            hit = lex_byte(pend_byte, b, !e);
         if (!hit && e)
            hit = lex_byte(b, 8'h00, 1'b0);
         if (hit) begin
            v = '{1'b1, row, col};
            got = 1'b1;
            reported = 1'b1;
         end else if (e) begin
            got = 1'b1;
         end
      end
      if (e) begin
         start_file();
      end else begin
         pend_byte = b;
         pend_ok = 1'b1;
      end
   endfunction

   function automatic logic [7:0] plain_char();
      case ($urandom_range(9))
         0: return 8'h20;
         1: return 8'h30 + 8'($urandom_range(9));
         default: return 8'h61 + 8'($urandom_range(25));
      endcase
   endfunction

   function automatic logic [7:0] special_char();
      case ($urandom_range(6))
         0: return CH_SLASH;
         1: return CH_STAR;
         2: return CH_DQUOTE;
         3: return CH_BSLASH;
         4: return CH_SQUOTE;
         5: return CH_NL;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic void add_body(input int n, input logic [7:0] quote);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(7))
            0: begin
               src.push_back(CH_BSLASH);
               src.push_back($urandom_range(1) ? quote : CH_BSLASH);
            end
            1: src.push_back(special_char());
            default: src.push_back(plain_char());
         endcase
      end
   endfunction

   function automatic void add_token();
      case ($urandom_range(11))
         0, 1, 2: begin
            src.push_back(CH_SQUOTE);
            add_body($urandom_range(limit_q + 2), CH_SQUOTE);
            if ($urandom_range(9) != 0)
               src.push_back(CH_SQUOTE);
         end
         3: begin
            src.push_back(CH_DQUOTE);
            add_body($urandom_range(8), CH_DQUOTE);
            if ($urandom_range(9) != 0)
               src.push_back(CH_DQUOTE);
         end
         4: begin
            src.push_back(CH_SLASH);
            src.push_back(CH_SLASH);
            add_body($urandom_range(6), CH_SQUOTE);
            src.push_back(CH_NL);
         end
         5: begin
            src.push_back(CH_SLASH);
            src.push_back(CH_STAR);
            add_body($urandom_range(6), CH_SQUOTE);
            src.push_back(CH_STAR);
            src.push_back(CH_SLASH);
         end
         6: src.push_back(CH_NL);
         7, 8: repeat ($urandom_range(1, 6)) src.push_back(plain_char());
         9, 10: src.push_back(special_char());
         default: src.push_back(8'($urandom_range(255)));
      endcase
   endfunction

   function automatic void build_file(input int max_tok);
      src.delete();
      if ($urandom_range(9) == 0) begin
         // raw noise file
         repeat ($urandom_range(1, 12))
            src.push_back($urandom_range(1) ? special_char() : 8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(1, max_tok)) add_token();
      end
   endfunction

   task automatic put_byte(input logic [7:0] b, input bit e, output bit got,
                           output verdict_type v);
      int gap;
      gap = 0;
      while (gap < 60 && $urandom_range(99) < tx_pct)
         gap++;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_source_byte <= b;
      req_end_of_file <= e;
      do @(posedge clock); while (req_stall);
      take_byte(b, e, got, v);
   endtask

   // stop sending and let every pending verdict come out
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (verdicts.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [3:0] val);
      quiesce();
      @(negedge clock);
      csr_valid      <= 1'b1;
      csr_char_limit <= val;
      do @(posedge clock); while (!csr_ready);
      limit_q = val;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("[c_char_literal_length_checker_core] ERROR");
      $finish;
   end

   // result side backpressure, with an optional long hold-off
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts.size() == 0) begin
            $display("%0t: unexpected beat: expected none, got found %0d row %0d col %0d",
                     $time, rsp_found, rsp_row_number, rsp_column_number);
            errors++;
         end else begin
            head = verdicts.pop_front();
            if (rsp_found !== head.found) begin
               $display("%0t: found: expected %0d, got %0d", $time, head.found, rsp_found);
               errors++;
            end
            if (rsp_row_number !== head.row) begin
               $display("%0t: row: expected %0d, got %0d", $time, head.row, rsp_row_number);
               errors++;
            end
            if (rsp_column_number !== head.col) begin
               $display("%0t: column: expected %0d, got %0d",
                        $time, head.col, rsp_column_number);
               errors++;
            end
         end
      end
   end

   initial begin
      bit got;
      bit paused;
      verdict_type v;
      int sent;
      logic [3:0] lim;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_source_byte = 8'h00;
      req_end_of_file = 1'b0;
      csr_valid       = 1'b0;
      csr_char_limit  = 4'd0;
      paused          = 1'b0;
      limit_q         = CHAR_LIMIT_RESET;
      start_file();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         put_byte(plan[i].data, plan[i].last, got, v);
         if (plan[i].typed) begin
            if (plan[i].has_res)
               verdicts.push_back('{plan[i].found, plan[i].row, plan[i].col});
         end else if (got) begin
            verdicts.push_back(v);
         end
      end

      for (int phase = 0; phase < 8; phase++) begin
         lim = (phase == 3 || phase == 7) ? 4'($urandom_range(15)) : limit_plan[phase];
         write_limit(lim);
         tx_pct = (phase % 4 == 1) ? 87 : (phase % 4 == 3) ? 16 : 0;
         rx_pct = (phase % 4 == 2) ? 87 : (phase % 4 == 3) ? 16 : 0;
         // long receiver hold-off while bytes keep coming, to back up the pipe
         if (phase == 0)
            hold_req = 400;
         sent = 0;
         while (sent < 180) begin
            if (phase == 5 && sent >= 100 && !paused) begin
               quiesce();
               paused = 1'b1;
            end
            build_file(phase == 0 ? 3 : 8);
            foreach (src[i]) begin
               put_byte(src[i], i == src.size() - 1, got, v);
               if (got)
                  verdicts.push_back(v);
            end
            sent += src.size();
         end
      end

      quiesce();
      if (errors == 0)
         $display("[c_char_literal_length_checker_core] OK");
      else
         $display("[c_char_literal_length_checker_core] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/cclc_pkg.sv
hdl/cclc_scan.sv
hdl/c_char_literal_length_checker_core.sv
sim/c_char_literal_length_checker_core_tb.sv
